// ----- src/deadline_drop_fifo_with_byte_credit_unit_assert.svh -----
// assertion macros shared by the rtl files of the deadline drop fifo
`ifndef DEADLINE_DROP_FIFO_WITH_BYTE_CREDIT_UNIT_ASSERT_SVH
`define DEADLINE_DROP_FIFO_WITH_BYTE_CREDIT_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define DDF_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ddf assertion failed");

// next-cycle implication, checked outside reset
`define DDF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ddf assertion failed");

`endif

// ----- src/ddfbc_pkg.sv -----
// types, codes and constants of the deadline drop fifo with byte credit
package ddfbc_pkg;

  localparam int DDF_DEPTH     = 8192;
  localparam int DDF_TIME_BITS = 16;

  localparam int CMD_W      = 2;
  localparam int STAT_W     = 3;
  localparam int AGE_W      = 16;
  localparam int CREDIT_W   = 16;
  localparam int SIZE_W     = 12;
  localparam int OCC_W      = 14;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CMD_W-1:0] CMD_ENQ   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SERVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NONE  = 2'd3;

  localparam logic [STAT_W-1:0] STAT_ENQ      = 3'd0;
  localparam logic [STAT_W-1:0] STAT_FULL     = 3'd1;
  localparam logic [STAT_W-1:0] STAT_SENT     = 3'd2;
  localparam logic [STAT_W-1:0] STAT_DROPPED  = 3'd3;
  localparam logic [STAT_W-1:0] STAT_EMPTY    = 3'd4;
  localparam logic [STAT_W-1:0] STAT_NOCREDIT = 3'd5;
  localparam logic [STAT_W-1:0] STAT_TICKED   = 3'd6;

  localparam logic [CFG_IDX_W-1:0] CFG_BUDGET    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SMALL_SZ  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LARGE_SZ  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SMALL_AGE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LARGE_AGE = 3'd4;

  localparam logic [CREDIT_W-1:0] RST_BUDGET    = 16'd64000;
  localparam logic [SIZE_W-1:0]   RST_SMALL_SZ  = 12'd80;
  localparam logic [SIZE_W-1:0]   RST_LARGE_SZ  = 12'd400;
  localparam logic [AGE_W-1:0]    RST_SMALL_AGE = 16'd14;
  localparam logic [AGE_W-1:0]    RST_LARGE_AGE = 16'd1;

  typedef struct packed {
    logic push;
    logic rd_en;
    logic pop;
  } q_ctrl_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage

// ----- src/ddfbc_queue.sv -----
// circular entry store with head and tail pointers and fill count
module ddfbc_queue
  import ddfbc_pkg::*;
#(
  parameter int DEPTH     = DDF_DEPTH,
  parameter int TIME_BITS = DDF_TIME_BITS,
  localparam int PTR_W    = $clog2(DEPTH),
  localparam int CNT_W    = $clog2(DEPTH + 1)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  q_ctrl_t              ctrl,
  input  logic                 wr_class,
  input  logic [TIME_BITS-1:0] wr_stamp,
  output logic                 rd_class,
  output logic [TIME_BITS-1:0] rd_stamp,
  output q_stat_t              stat,
  output logic [CNT_W-1:0]     fill
);

  localparam int ENTRY_W = TIME_BITS + 1;
  localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [ENTRY_W-1:0] mem_r [DEPTH];
  logic [ENTRY_W-1:0] rd_data_r;
  logic [PTR_W-1:0]   head_r, head_nxt;
  logic [PTR_W-1:0]   tail_r, tail_nxt;
  logic [CNT_W-1:0]   fill_r, fill_nxt;

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      mem_r[tail_r] <= {wr_class, wr_stamp};
    end
    if (ctrl.rd_en) begin
      rd_data_r <= mem_r[head_r];
    end
  end

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    fill_nxt = fill_r;
    if (ctrl.push) begin
      tail_nxt = (tail_r == LAST_IDX) ? '0 : tail_r + 1'b1;
      fill_nxt = fill_r + 1'b1;
    end
    if (ctrl.pop) begin
      head_nxt = (head_r == LAST_IDX) ? '0 : head_r + 1'b1;
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      fill_r <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      fill_r <= fill_nxt;
    end
  end

  assign rd_class   = rd_data_r[ENTRY_W-1];
  assign rd_stamp   = rd_data_r[TIME_BITS-1:0];
  assign stat.empty = (fill_r == '0);
  assign stat.full  = (fill_r == FULL_CNT);
  assign fill       = fill_r;

`include "deadline_drop_fifo_with_byte_credit_unit_assert.svh"
  `DDF_ASSERT_IMPL(a_push_not_full, ctrl.push, !stat.full)
  `DDF_ASSERT_IMPL(a_pop_not_empty, ctrl.pop, !stat.empty)
  `DDF_ASSERT_IMPL(a_no_push_with_pop, ctrl.push, !ctrl.pop && !ctrl.rd_en)
  `DDF_ASSERT_NEXT(a_pop_count, ctrl.pop, fill_r == $past(fill_r) - 1'b1)

endmodule

// ----- src/deadline_drop_fifo_with_byte_credit_unit.sv -----
// top level of the deadline drop packet fifo with byte credit
// Usage: a command word (in_cmd, in_pkt_class) is taken at a rising edge with
// start high and busy low. cmd enqueue stamps the class with the current time,
// serve pops the head when credit remains, tick advances time and reloads the
// credit from budget_r. Unused command code 3 is swallowed with no result.
// Each command gives one result word, shown for a single cycle with out_valid
// high; the receiver cannot stall, so it must take it in that cycle.
// Enqueue, tick and a serve that finds the queue empty or the credit at zero
// give the result in the cycle after acceptance; a serve that pops reads the
// head entry from the synchronous entry memory first, so busy is high for one
// cycle, and the result is registered from that entry while busy is high.
// Throughput: one command per cycle while busy is low; a popping serve stalls it.
// Configuration words are written on the cfg_ channel (index, data) while idle.
// Reset (rst_n low, synchronous) clears pointers, fill count, time and credit
// and loads register defaults; the entry memory is not cleared, as every entry
// is written before it is read.
module deadline_drop_fifo_with_byte_credit_unit
  import ddfbc_pkg::*;
#(
  parameter int DEPTH     = DDF_DEPTH,
  parameter int TIME_BITS = DDF_TIME_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [CMD_W-1:0]      in_cmd,
  input  logic                  in_pkt_class,
  output logic                  out_valid,
  output logic [STAT_W-1:0]     out_status,
  output logic                  out_class,
  output logic [AGE_W-1:0]      out_age,
  output logic [CREDIT_W-1:0]   out_credit_left,
  output logic [OCC_W-1:0]      out_occupancy,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (TIME_BITS > AGE_W) ? TIME_BITS : AGE_W;

  logic [CREDIT_W-1:0]  budget_r;
  logic [SIZE_W-1:0]    small_sz_r, large_sz_r;
  logic [AGE_W-1:0]     small_age_r, large_age_r;

  logic [TIME_BITS-1:0] now_r, now_nxt;
  logic [CREDIT_W-1:0]  credit_r, credit_nxt;
  logic                 busy_r, busy_nxt;
  logic                 valid_r, valid_nxt;
  logic [STAT_W-1:0]    status_r, status_nxt;
  logic                 class_r, class_nxt;
  logic [AGE_W-1:0]     age_r, age_nxt;

  q_ctrl_t              q_ctrl;
  q_stat_t              q_stat;
  logic                 rd_class;
  logic [TIME_BITS-1:0] rd_stamp;
  logic [CNT_W-1:0]     fill;

  logic                 accept;
  logic [TIME_BITS-1:0] head_age;
  logic [AGE_W-1:0]     limit;
  logic [SIZE_W-1:0]    charge;

  ddfbc_queue #(
    .DEPTH     (DEPTH),
    .TIME_BITS (TIME_BITS)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (q_ctrl),
    .wr_class (in_pkt_class),
    .wr_stamp (now_r),
    .rd_class (rd_class),
    .rd_stamp (rd_stamp),
    .stat     (q_stat),
    .fill     (fill)
  );

  assign accept    = start && !busy_r;
  assign cfg_ready = !busy_r;

  // head entry is valid only in the busy cycle; time does not move meanwhile
  assign head_age = now_r - rd_stamp;
  assign limit    = rd_class ? large_age_r : small_age_r;
  assign charge   = rd_class ? large_sz_r : small_sz_r;

  always_comb begin
    now_nxt      = now_r;
    credit_nxt   = credit_r;
    busy_nxt     = 1'b0;
    valid_nxt    = 1'b0;
    status_nxt   = status_r;
    class_nxt    = 1'b0;
    age_nxt      = '0;
    q_ctrl.push  = 1'b0;
    q_ctrl.rd_en = 1'b0;
    q_ctrl.pop   = 1'b0;
    if (busy_r) begin
      q_ctrl.pop = 1'b1;
      valid_nxt  = 1'b1;
      class_nxt  = rd_class;
      age_nxt    = AGE_W'(head_age);
      if (CMP_W'(head_age) > CMP_W'(limit)) begin
        status_nxt = STAT_DROPPED;
      end else begin
        status_nxt = STAT_SENT;
        credit_nxt = (credit_r > CREDIT_W'(charge)) ? credit_r - CREDIT_W'(charge) : '0;
      end
    end else if (accept) begin
      unique case (in_cmd)
        CMD_ENQ: begin
          valid_nxt = 1'b1;
          if (q_stat.full) begin
            status_nxt = STAT_FULL;
          end else begin
            status_nxt  = STAT_ENQ;
            q_ctrl.push = 1'b1;
          end
        end
        CMD_SERVE: begin
          if (q_stat.empty) begin
            valid_nxt  = 1'b1;
            status_nxt = STAT_EMPTY;
          end else if (credit_r == '0) begin
            valid_nxt  = 1'b1;
            status_nxt = STAT_NOCREDIT;
          end else begin
            q_ctrl.rd_en = 1'b1;
            busy_nxt     = 1'b1;
          end
        end
        CMD_TICK: begin
          valid_nxt  = 1'b1;
          status_nxt = STAT_TICKED;
          now_nxt    = now_r + 1'b1;
          credit_nxt = budget_r;
        end
        CMD_NONE: begin
          valid_nxt = 1'b0;
        end
        default: begin
          valid_nxt = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r    <= '0;
      credit_r <= '0;
      busy_r   <= 1'b0;
      valid_r  <= 1'b0;
    end else begin
      now_r    <= now_nxt;
      credit_r <= credit_nxt;
      busy_r   <= busy_nxt;
      valid_r  <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    class_r  <= class_nxt;
    age_r    <= age_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      budget_r    <= RST_BUDGET;
      small_sz_r  <= RST_SMALL_SZ;
      large_sz_r  <= RST_LARGE_SZ;
      small_age_r <= RST_SMALL_AGE;
      large_age_r <= RST_LARGE_AGE;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_BUDGET:    budget_r    <= cfg_data;
        CFG_SMALL_SZ:  small_sz_r  <= cfg_data[SIZE_W-1:0];
        CFG_LARGE_SZ:  large_sz_r  <= cfg_data[SIZE_W-1:0];
        CFG_SMALL_AGE: small_age_r <= cfg_data;
        CFG_LARGE_AGE: large_age_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // credit and fill are already updated when the result word is shown
  assign busy            = busy_r;
  assign out_valid       = valid_r;
  assign out_status      = status_r;
  assign out_class       = class_r;
  assign out_age         = age_r;
  assign out_credit_left = credit_r;
  assign out_occupancy   = OCC_W'(fill);

`include "deadline_drop_fifo_with_byte_credit_unit_assert.svh"
  `DDF_ASSERT_NEXT(a_busy_one_cycle, busy_r, !busy_r && valid_r)
  `DDF_ASSERT_NEXT(a_pop_serve_busy, accept && in_cmd == CMD_SERVE && !q_stat.empty && credit_r != '0, busy_r)
  `DDF_ASSERT_NEXT(a_unused_silent, accept && in_cmd == CMD_NONE, !valid_r)
  `DDF_ASSERT_IMPL(a_empty_occ, valid_r && status_r == STAT_EMPTY, fill == '0)
  `DDF_ASSERT_NEXT(a_drop_keeps_credit, busy_r && CMP_W'(head_age) > CMP_W'(limit), credit_r == $past(credit_r))

endmodule
